FILE: rtl/qrs_pkg.sv
// shared types, widths and codes for the quadratic root solver
// no dependencies
`default_nettype none
package qrs_pkg;
    localparam int CoefW  = 16;
    localparam int DiscW  = 35;   // |b*b - 4ac| fits in 34 bits, plus sign
    localparam int RadW   = 64;   // |disc| << 30
    localparam int RootW  = 32;   // floor sqrt of radicand
    localparam int NumW   = 34;   // signed numerator -b*32768 +- s
    localparam int QuoW   = 34;   // |numerator| / |a| magnitude bits
    localparam int ValW   = 32;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_COMPLEX = 2'd1,
        KIND_REPEAT  = 2'd2,
        KIND_AZERO   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  a_neg;
        logic  [CoefW-1:0] a_mag;
        logic  signed [CoefW-1:0] b;
    } t_ctl;
endpackage
`default_nettype wire

FILE: rtl/qrs_sqrt.sv
// pipelined bit-serial integer square root, one result bit per stage
// depends on qrs_pkg
`default_nettype none
module qrs_sqrt import qrs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [RadW-1:0]    i_rad,
    output logic [RootW-1:0]        o_root
);
    logic [RadW-1:0]  r_rem  [0:RootW];
    logic [RootW-1:0] r_root [0:RootW];

    assign r_rem[0]  = i_rad;
    assign r_root[0] = '0;

    for (genvar g = 0; g < RootW; g++) begin : g_st
        logic [RadW-1:0]  n_rem;
        logic [RootW-1:0] n_root;
        logic [RootW+1:0] w_trial;
        logic [RootW+1:0] w_top;
        always_comb begin
            w_top   = (RootW+2)'(r_rem[g] >> (2*(RootW-1-g)));
            w_trial = {r_root[g], 2'b01};
            n_rem   = r_rem[g];
            n_root  = {r_root[g][RootW-2:0], 1'b0};
            if (w_top >= w_trial) begin
                n_rem  = r_rem[g] - (RadW'(w_trial) << (2*(RootW-1-g)));
                n_root = {r_root[g][RootW-2:0], 1'b1};
            end
        end
        if (g == RootW-1) begin : g_last
            assign r_rem[g+1]  = n_rem;
            assign r_root[g+1] = n_root;
        end else begin : g_reg
            logic [RadW-1:0]  r_r;
            logic [RootW-1:0] r_q;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r <= n_rem;
                    r_q <= n_root;
                end
            end
            assign r_rem[g+1]  = r_r;
            assign r_root[g+1] = r_q;
        end
    end

    assign o_root = r_root[RootW];
endmodule
`default_nettype wire

FILE: rtl/qrs_div.sv
// pipelined restoring divider of two magnitudes, one quotient bit per stage
// depends on qrs_pkg
`default_nettype none
module qrs_div import qrs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [QuoW-1:0]   i_num,
    input  wire logic [CoefW-1:0]  i_den,
    output logic [QuoW-1:0]        o_quo
);
    logic [QuoW-1:0]  r_n [0:QuoW];
    logic [CoefW-1:0] r_d [0:QuoW];
    logic [CoefW:0]   r_p [0:QuoW];

    assign r_n[0] = i_num;
    assign r_d[0] = i_den;
    assign r_p[0] = '0;

    for (genvar g = 0; g < QuoW; g++) begin : g_st
        logic [CoefW+1:0] w_sh;
        logic [CoefW:0]   n_p;
        logic [QuoW-1:0]  n_n;
        always_comb begin
            w_sh = {r_p[g], r_n[g][QuoW-1]};
            n_n  = {r_n[g][QuoW-2:0], 1'b0};
            n_p  = w_sh[CoefW:0];
            if (w_sh >= {2'b00, r_d[g]}) begin
                n_p    = (CoefW+1)'(w_sh - {2'b00, r_d[g]});
                n_n[0] = 1'b1;
            end
        end
        if (g % 2 == 1 || g == QuoW-1) begin : g_reg
            logic [QuoW-1:0]  r_nq;
            logic [CoefW-1:0] r_dq;
            logic [CoefW:0]   r_pq;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nq <= n_n;
                    r_dq <= r_d[g];
                    r_pq <= n_p;
                end
            end
            assign r_n[g+1] = r_nq;
            assign r_d[g+1] = r_dq;
            assign r_p[g+1] = r_pq;
        end else begin : g_comb
            assign r_n[g+1] = n_n;
            assign r_d[g+1] = r_d[g];
            assign r_p[g+1] = n_p;
        end
    end

    assign o_quo = r_n[QuoW];
endmodule
`default_nettype wire

FILE: rtl/quadratic_root_solver.sv
// Quadratic root solver: one coefficient set per cycle, fully pipelined.
// An item's result is offered after it passes a product register, a discriminant
// register, 31 square root registers (the last root bit settles in the numerator
// cycle), a numerator register, 17 divider registers of two quotient bits each and
// the output register. An item enters every cycle while the output is taken; a
// stalled output freezes the whole pipeline.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // first_value [31:0], second_value [63:32]
    output logic [2:0]       m_axis_tuser    // kind [1:0], saturated [2]
);
    localparam int SqL  = RootW - 1;
    localparam int DvL  = QuoW / 2;
    localparam int Lat  = 1 + 1 + SqL + 1 + DvL + 1;

    logic w_en;
    logic [Lat-1:0] r_vld;
    assign w_en = !r_vld[Lat-1] || m_axis_tready;
    assign s_axis_tready = w_en && i_rst_n;
    assign m_axis_tvalid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
    end

    // stage 1: products
    logic signed [CoefW-1:0] r_a, r_b;
    logic signed [31:0] r_bb, r_ac;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a  <= s_axis_tdata[15:0];
            r_b  <= s_axis_tdata[31:16];
            r_bb <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
            r_ac <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[47:32]);
        end
    end

    // stage 2: discriminant
    logic signed [DiscW-1:0] w_di;
    logic [RadW-1:0] r_rad;
    t_ctl r_ctl2;
    assign w_di = DiscW'(r_bb) - (DiscW'(r_ac) <<< 2);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad        <= RadW'(w_di[DiscW-1] ? -w_di : w_di) << 30;
            r_ctl2.a_neg <= r_a[CoefW-1];
            r_ctl2.a_mag <= r_a[CoefW-1] ? CoefW'(-r_a) : r_a;
            r_ctl2.b     <= r_b;
            if (r_a == '0)                r_ctl2.kind <= KIND_AZERO;
            else if (w_di[DiscW-1])       r_ctl2.kind <= KIND_COMPLEX;
            else if (w_di == '0)          r_ctl2.kind <= KIND_REPEAT;
            else                          r_ctl2.kind <= KIND_REAL;
        end
    end

    logic [RootW-1:0] w_s;
    qrs_sqrt u_sqrt (.i_clk(i_clk), .i_en(w_en), .i_rad(r_rad), .o_root(w_s));

    t_ctl r_ctl_sq [0:SqL-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl_sq[0] <= r_ctl2;
            for (int k = 1; k < SqL; k++) r_ctl_sq[k] <= r_ctl_sq[k-1];
        end
    end
    t_ctl w_c3;
    assign w_c3 = r_ctl_sq[SqL-1];

    // numerator stage
    logic signed [NumW:0] w_nb, w_n1, w_n2;
    logic [QuoW-1:0] r_m1, r_m2;
    logic r_s1, r_s2;
    t_ctl r_ctl4;
    always_comb begin
        w_nb = -((NumW+1)'(w_c3.b) <<< 15);
        w_n1 = w_nb;
        w_n2 = (NumW+1)'({1'b0, w_s});
        if (w_c3.kind == KIND_REAL) begin
            w_n1 = w_nb + (NumW+1)'({1'b0, w_s});
            w_n2 = w_nb - (NumW+1)'({1'b0, w_s});
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1   <= w_n1[NumW];
            r_s2   <= w_n2[NumW] && (w_c3.kind == KIND_REAL);
            r_m1   <= QuoW'(w_n1[NumW] ? -w_n1 : w_n1);
            r_m2   <= QuoW'(w_n2[NumW] ? -w_n2 : w_n2);
            r_ctl4 <= w_c3;
        end
    end

    logic [QuoW-1:0] w_q1, w_q2;
    qrs_div u_div1 (.i_clk(i_clk), .i_en(w_en), .i_num(r_m1),
                    .i_den(r_ctl4.a_mag), .o_quo(w_q1));
    qrs_div u_div2 (.i_clk(i_clk), .i_en(w_en), .i_num(r_m2),
                    .i_den(r_ctl4.a_mag), .o_quo(w_q2));

    t_ctl r_ctl_dv [0:DvL-1];
    logic [DvL-1:0] r_sg1, r_sg2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl_dv[0] <= r_ctl4;
            r_sg1 <= {r_sg1[DvL-2:0], r_s1};
            r_sg2 <= {r_sg2[DvL-2:0], r_s2};
            for (int k = 1; k < DvL; k++) r_ctl_dv[k] <= r_ctl_dv[k-1];
        end
    end
    t_ctl w_c5;
    assign w_c5 = r_ctl_dv[DvL-1];

    // sign and clip
    logic w_neg1, w_neg2, w_sat1, w_sat2;
    logic [ValW-1:0] w_v1, w_v2;
    always_comb begin
        w_neg1 = r_sg1[DvL-1] ^ w_c5.a_neg;
        w_neg2 = (w_c5.kind == KIND_REAL) ? (r_sg2[DvL-1] ^ w_c5.a_neg) : 1'b0;
        w_sat1 = w_neg1 ? (w_q1 > QuoW'(34'h080000000)) : (w_q1 > QuoW'(34'h07fffffff));
        w_sat2 = w_neg2 ? (w_q2 > QuoW'(34'h080000000)) : (w_q2 > QuoW'(34'h07fffffff));
        w_v1 = w_sat1 ? (w_neg1 ? 32'h80000000 : 32'h7fffffff)
                      : (w_neg1 ? ValW'(-w_q1) : ValW'(w_q1));
        w_v2 = w_sat2 ? (w_neg2 ? 32'h80000000 : 32'h7fffffff)
                      : (w_neg2 ? ValW'(-w_q2) : ValW'(w_q2));
        if (w_c5.kind == KIND_REPEAT) begin
            w_v2 = w_v1; w_sat2 = 1'b0;
        end
        if (w_c5.kind == KIND_AZERO) begin
            w_v1 = '0; w_v2 = '0; w_sat1 = 1'b0; w_sat2 = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata <= {w_v2, w_v1};
            m_axis_tuser <= {w_sat1 | w_sat2, w_c5.kind};
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_azero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == KIND_AZERO |-> m_axis_tdata == '0)
        else $error("zero a gave nonzero roots");
    a_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == KIND_REPEAT
        |-> m_axis_tdata[63:32] == m_axis_tdata[31:0])
        else $error("repeated root mismatch");
`endif
endmodule
`default_nettype wire
